FILE: hdl/mms_pkg.sv
// Shared types and constants for the min-max stretch block.
`timescale 1ns / 1ps

package mms_pkg;

    // Item command codes
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Output full scale and quotient length
    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam int DIV_STEPS = 8;
    localparam int STEP_WIDTH = $clog2(DIV_STEPS);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    // Pixel source chosen at the convert transfer
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_FULL,
        SEL_DIV
    } pix_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic measure;
        logic load;
        logic prep;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic trivial;
    } dp_status_t;

endpackage

FILE: hdl/mms_datapath.sv
// Datapath: running min/max, offset and span, restoring divider and rounding.
`timescale 1ns / 1ps

module mms_datapath #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mms_pkg::dp_cmd_t    dp_cmd,
    output mms_pkg::dp_status_t dp_status,
    input  logic [31:0]         sample,
    input  logic                first,
    output logic [7:0]          pixel
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int NW = SAMPLE_WIDTH + 8;

    logic signed [W-1:0]  v;
    logic signed [W-1:0]  least_reg;
    logic signed [W-1:0]  greatest_reg;
    logic                 any_seen_reg;
    logic signed [W:0]    offs_full;
    logic signed [W:0]    span_full;
    logic [W-1:0]         offs_reg;
    logic [W-1:0]         span_reg;
    mms_pkg::pix_sel_t    sel_reg;
    mms_pkg::pix_sel_t    sel_next;
    logic [NW-1:0]        rem_reg;
    logic [NW-1:0]        div_reg;
    logic [7:0]           quo_reg;
    logic [7:0]           pixel_reg;
    logic [NW-1:0]        num;
    logic                 rem_ge;
    logic [W:0]           twice_rem;
    logic [W:0]           den;
    logic                 round_up;

    // Take the low sample bits as a signed value
    assign v = $signed(sample[W-1:0]);

    // Offset of the sample and span of the frame, one bit wider
    assign offs_full = $signed({v[W-1], v}) - $signed({least_reg[W-1], least_reg});
    assign span_full = $signed({greatest_reg[W-1], greatest_reg})
                     - $signed({least_reg[W-1], least_reg});

    // Classify the convert item
    always_comb
    begin
        if (!any_seen_reg || span_full == '0 || offs_full <= 0)
            sel_next = mms_pkg::SEL_ZERO;
        else if (offs_full >= span_full)
            sel_next = mms_pkg::SEL_FULL;
        else
            sel_next = mms_pkg::SEL_DIV;
    end

    // Update running min and max on measure transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            least_reg    <= '0;
            greatest_reg <= '0;
            any_seen_reg <= 1'b0;
        end
        else if (dp_cmd.measure)
        begin
            any_seen_reg <= 1'b1;
            if (first || !any_seen_reg)
            begin
                least_reg    <= v;
                greatest_reg <= v;
            end
            else
            begin
                if (v < least_reg)
                    least_reg <= v;
                if (v > greatest_reg)
                    greatest_reg <= v;
            end
        end
    end

    // Numerator offs * 255 as a shift and subtract
    assign num = {offs_reg, 8'd0} - {8'd0, offs_reg};

    // One restoring divider step compare
    assign rem_ge = (rem_reg >= div_reg);

    // Round to nearest, ties to even, from the final remainder
    assign twice_rem = {rem_reg[W-1:0], 1'b0};
    assign den       = {1'b0, span_reg};
    assign round_up  = (twice_rem > den) || ((twice_rem == den) && quo_reg[0]);

    // Hold operands, iterate the divider, register the pixel
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            offs_reg <= offs_full[W-1:0];
            span_reg <= span_full[W-1:0];
            sel_reg  <= sel_next;
        end
        if (dp_cmd.prep)
        begin
            rem_reg <= num;
            div_reg <= {1'b0, span_reg, 7'd0};
            quo_reg <= '0;
        end
        if (dp_cmd.div_step)
        begin
            if (rem_ge)
                rem_reg <= rem_reg - div_reg;
            quo_reg <= {quo_reg[6:0], rem_ge};
            div_reg <= {1'b0, div_reg[NW-1:1]};
        end
        if (dp_cmd.finish)
        begin
            case (sel_reg)
                mms_pkg::SEL_FULL: pixel_reg <= mms_pkg::FULL_SCALE;
                mms_pkg::SEL_DIV:  pixel_reg <= quo_reg + {7'd0, round_up};
                default:           pixel_reg <= 8'd0;
            endcase
        end
    end

    assign dp_status.trivial = (sel_reg != mms_pkg::SEL_DIV);
    assign pixel = pixel_reg;

    // Running extremes stay ordered once anything is measured
    assert property (@(posedge clk) disable iff (!rst_n)
        any_seen_reg |-> (least_reg <= greatest_reg))
        else $error("running minimum above running maximum");

endmodule

FILE: hdl/mms_ctrl.sv
// Controller: sequences measure and convert items and drives busy and done.
`timescale 1ns / 1ps

module mms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  mms_pkg::dp_status_t dp_status,
    output mms_pkg::dp_cmd_t    dp_cmd,
    output logic                busy,
    output logic                done
);

    mms_pkg::state_t                 state_reg;
    mms_pkg::state_t                 state_next;
    logic [mms_pkg::STEP_WIDTH-1:0]  step_reg;
    logic [mms_pkg::STEP_WIDTH-1:0]  step_next;
    logic                            done_reg;
    logic                            done_next;

    // Hold state, step count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mms_pkg::ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Advance the sequence and issue datapath commands
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        done_next       = 1'b0;
        dp_cmd          = '0;
        unique case (state_reg)
            mms_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == mms_pkg::CMD_MEASURE)
                        dp_cmd.measure = 1'b1;
                    else
                    begin
                        dp_cmd.load = 1'b1;
                        state_next  = mms_pkg::ST_PREP;
                    end
                end
            end
            mms_pkg::ST_PREP:
            begin
                dp_cmd.prep = 1'b1;
                step_next   = '0;
                if (dp_status.trivial)
                    state_next = mms_pkg::ST_FIN;
                else
                    state_next = mms_pkg::ST_DIV;
            end
            mms_pkg::ST_DIV:
            begin
                dp_cmd.div_step = 1'b1;
                if (step_reg == mms_pkg::STEP_WIDTH'(mms_pkg::DIV_STEPS - 1))
                    state_next = mms_pkg::ST_FIN;
                else
                    step_next = step_reg + 1'b1;
            end
            mms_pkg::ST_FIN:
            begin
                dp_cmd.finish = 1'b1;
                done_next     = 1'b1;
                state_next    = mms_pkg::ST_IDLE;
            end
            default:
                state_next = mms_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != mms_pkg::ST_IDLE);
    assign done = done_reg;

    // Result strobe follows in the cycle after the rounding step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mms_pkg::ST_FIN) |=> done_reg)
        else $error("no result strobe after rounding step");

    // Strobe only appears once the sequence is back at rest
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == mms_pkg::ST_IDLE))
        else $error("result strobe while still busy");

    // Divider step count stays within the quotient length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mms_pkg::ST_DIV) |-> (step_reg < mms_pkg::DIV_STEPS))
        else $error("divider step count overrun");

    // A measure command never starts a convert sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.measure |=> (state_reg == mms_pkg::ST_IDLE))
        else $error("measure item left the controller busy");

endmodule

FILE: hdl/minmax_stretch_to_8bit.sv
// Top level of the min-max stretch to 8-bit pixel block.
`timescale 1ns / 1ps

// A transfer takes place when start is high and busy is low. Measure items
// (cmd = 0) fold the sample into the running minimum and maximum at the
// transfer itself, give no result and leave busy low, so one can follow in
// every cycle. Convert items (cmd = 1) raise busy while the block forms the
// numerator, runs eight steps of the restoring divider that yields one
// quotient bit a cycle and rounds; the pixel then appears with done high for
// exactly one cycle, which is also the first cycle a new item can transfer.
// A convert item with a flat frame, nothing measured, or a sample at or
// beyond either extreme skips the divider. The receiver cannot stall: pixel
// is valid only in the cycle that done is high.
module minmax_stretch_to_8bit #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [31:0] sample,
    input  logic        first,
    output logic        done,
    output logic [7:0]  pixel
);

    mms_pkg::dp_cmd_t    dp_cmd;
    mms_pkg::dp_status_t dp_status;

    // Sequence the items
    mms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd),
        .busy      (busy),
        .done      (done)
    );

    // Compute extremes and pixels
    mms_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .sample    (sample),
        .first     (first),
        .pixel     (pixel)
    );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the min-max stretch to 8-bit pixel block.
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_WIDTH = 32;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS = 270;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [31:0] sample;
    logic        first;
    logic        done;
    logic [7:0]  pixel;

    // Predicted range state
    longint range_lo = 0;
    longint range_hi = 0;
    bit     range_valid = 1'b0;

    logic [7:0] pending_pixels[$];
    int         error_count = 0;
    int         quiet_cycles = 0;
    int         gap_pct = 0;
    int         items_sent = 0;

    minmax_stretch_to_8bit #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .sample(sample),
        .first(first),
        .done(done),
        .pixel(pixel)
    );

    // Toggle the clock every half period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Sign-extend the used low bits of a raw sample
    function automatic longint sample_value(logic [31:0] raw);
        logic signed [SAMPLE_WIDTH-1:0] narrow;
        narrow = raw[SAMPLE_WIDTH-1:0];
        return longint'(narrow);
    endfunction

    // Fold one measured value into the running range
    function automatic void fold_into_range(longint v, logic restart);
        if (restart || !range_valid)
        begin
            range_lo = v;
            range_hi = v;
            range_valid = 1'b1;
        end
        else
        begin
            if (v < range_lo)
                range_lo = v;
            if (v > range_hi)
                range_hi = v;
        end
    endfunction

    // Scale a value to 0..255 against the range, round half to even
    function automatic logic [7:0] stretch_pixel(longint v);
        longint          span;
        longint          offs;
        longint unsigned num;
        longint unsigned q;
        longint unsigned r;
        if (!range_valid || range_hi <= range_lo)
            return 8'd0;
        span = range_hi - range_lo;
        offs = v - range_lo;
        if (offs <= 0)
            return 8'd0;
        if (offs >= span)
            return mms_pkg::FULL_SCALE;
        num = longint'(offs) * longint'(mms_pkg::FULL_SCALE);
        q = num / longint'(span);
        r = num % longint'(span);
        if (2 * r > span || (2 * r == span && q[0]))
            q++;
        if (q > mms_pkg::FULL_SCALE)
            q = mms_pkg::FULL_SCALE;
        return q[7:0];
    endfunction

    // Predict on each input transfer, check each pixel, watch for stalls
    always @(posedge clk)
    begin
        logic [7:0] expected;
        logic [7:0] predicted;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel: expected none, actual %0d", pixel);
                    error_count++;
                end
                else
                begin
                    expected = pending_pixels.pop_front();
                    if (pixel !== expected)
                    begin
                        $error("pixel: expected %0d, actual %0d", expected, pixel);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd == mms_pkg::CMD_MEASURE)
                    fold_into_range(sample_value(sample), first);
                else
                begin
                    predicted = stretch_pixel(sample_value(sample));
                    pending_pixels.insert(pending_pixels.size(), predicted);
                end
            end
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Send one item, idling at random first, and hold until the transfer
    task automatic send_item(input logic c, input logic [31:0] s, input logic f);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            cmd <= 1'($urandom_range(1));
            sample <= $urandom;
            first <= 1'($urandom_range(1));
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        start <= 1'b1;
        cmd <= c;
        sample <= s;
        first <= f;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic measure(input logic [31:0] s, input logic f);
        send_item(mms_pkg::CMD_MEASURE, s, f);
    endtask

    task automatic convert(input logic [31:0] s, input logic f);
        send_item(mms_pkg::CMD_CONVERT, s, f);
    endtask

    // Drop start and wait for every predicted pixel to arrive
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Convert before any measurement, then a measure without the first flag
    task automatic test_nothing_measured;
        convert(32'h7FFF_FFFF, 1'b1);
        convert(32'h8000_0000, 1'b0);
        measure(32'd5, 1'b0);
        convert(32'd5, 1'b0);
        convert(32'd6, 1'b1);
    endtask

    // Full signed span, with converts at both ends and in the middle
    task automatic test_extremes;
        measure(32'h8000_0000, 1'b1);
        measure(32'h7FFF_FFFF, 1'b0);
        convert(32'h8000_0000, 1'b0);
        convert(32'h7FFF_FFFF, 1'b0);
        convert(32'h0000_0000, 1'b0);
        convert(32'hFFFF_FFFF, 1'b1);
    endtask

    // Converted samples beyond either end of the range
    task automatic test_out_of_range;
        measure(-32'sd100, 1'b1);
        measure(32'd100, 1'b0);
        convert(-32'sd1000, 1'b0);
        convert(32'd1000, 1'b0);
    endtask

    // Exact halves rounding to the even neighbor, both up and down
    task automatic test_tie_rounding;
        measure(32'd0, 1'b1);
        measure(32'd6, 1'b0);
        convert(32'd1, 1'b0);
        convert(32'd3, 1'b0);
        convert(32'd5, 1'b0);
    endtask

    // Restart on a single value so max equals min
    task automatic test_flat_frame;
        measure(32'd7, 1'b1);
        convert(32'd7, 1'b0);
        convert(32'd8, 1'b0);
    endtask

    // Draw a sample as a center plus a random value in its low spread bits
    function automatic logic [31:0] near_value(logic [31:0] center, int spread);
        logic [63:0] mask;
        mask = (64'd1 << spread) - 64'd1;
        return center + ($urandom & mask[31:0]);
    endfunction

    // Random frames: measure pass then convert pass, with some broken frames
    task automatic test_random_frames(input int pct, input int count);
        logic [31:0]        center;
        logic [31:0]        s;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        int                 spread;
        int                 n_meas;
        int                 n_conv;
        int                 pick;
        bit                 broken;
        int                 stop_at;
        gap_pct = pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            center = $urandom;
            spread = $urandom_range(32);
            broken = ($urandom_range(9) == 0);
            n_meas = $urandom_range(1, 8);
            n_conv = $urandom_range(1, 10);
            lo = near_value(center, spread);
            hi = lo;
            for (int i = 0; i < n_meas; i++)
            begin
                s = near_value(center, spread);
                if (i == 0)
                    measure(s, !broken);
                else
                    measure(s, $urandom_range(19) == 0);
                if ($signed(s) < lo)
                    lo = s;
                if ($signed(s) > hi)
                    hi = s;
            end
            for (int i = 0; i < n_conv; i++)
            begin
                pick = $urandom_range(9);
                case (pick)
                    0: s = lo;
                    1: s = hi;
                    2: s = lo + 1;
                    3: s = hi - 1;
                    4: s = $urandom;
                    default: s = near_value(center, spread);
                endcase
                convert(s, 1'($urandom_range(1)));
            end
        end
        drain();
    endtask

    // Reset once, then run the directed and random tests in turn
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = mms_pkg::CMD_MEASURE;
        sample = '0;
        first = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_nothing_measured();
        test_extremes();
        test_out_of_range();
        test_tie_rounding();
        test_flat_frame();
        drain();

        test_random_frames(0, PHASE_ITEMS);
        test_random_frames(49, PHASE_ITEMS);
        test_random_frames(33, PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
